FILE: src/oam_pkg.sv
package oam_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = 12;
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 14;
    localparam int POS_W   = 25;
    localparam int IDX_W   = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

    localparam logic REQ_MASK  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic MODE_CUTOUT = 1'b0;
    localparam logic MODE_HOLLOW = 1'b1;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MASK_WIDTH   = 3'd2;
    localparam logic [2:0] REG_MASK_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_OFFSET_X     = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd5;
    localparam logic [2:0] REG_MASK_MODE    = 3'd6;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             last;
    } cnt_t;

    // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

FILE: src/oam_ram.sv
module oam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/oam_cnt.sv
module oam_cnt
    import oam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    output cnt_t             status
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             col_end, row_end;

    // compare with >= so a shrunk frame size still wraps
    assign col_end = ({1'b0, col_reg} + DIM_W'(1)) >= width;
    assign row_end = ({1'b0, row_reg} + DIM_W'(1)) >= height;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign status.col  = col_reg;
    assign status.row  = row_reg;
    assign status.last = col_end && row_end;

endmodule

FILE: src/offset_alpha_mask.sv
// offset_alpha_mask: RGBA stream with an offset alpha mask.
// A pixel item passes stage 1, stage 2 and the output register before the master side.
// Throughput: one item per cycle; all stages hold while m_tvalid is high, m_tready low.
// Rate is set by the single mask RAM read port (one lookup per pixel).
// Reset clears raster counters, pipeline valids and config (dims 256, offsets 0, cutout).
// The mask RAM is not cleared; entries hold garbage until written.
module offset_alpha_mask
    import oam_pkg::*;
#(
    parameter int MASK_PIXELS = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mask_index[15:0], mask_alpha[23:16], in_red[31:24], in_green[39:32],
    // in_blue[47:40], in_alpha[55:48]
    input  logic [55:0]      s_tdata,
    // req_type[0]
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    input  logic             cfg_wen,
    input  logic [2:0]       cfg_index,
    input  logic [OFS_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MASK_PIXELS);

    // config registers
    logic [DIM_W-1:0] img_w_reg, img_h_reg, msk_w_reg, msk_h_reg;
    logic [OFS_W-1:0] ofs_x_reg, ofs_y_reg;
    logic             mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= DIM_RESET;
            img_h_reg <= DIM_RESET;
            msk_w_reg <= DIM_RESET;
            msk_h_reg <= DIM_RESET;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
            mode_reg  <= MODE_CUTOUT;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_wdata[DIM_W-1:0];
                REG_MASK_WIDTH:   msk_w_reg <= cfg_wdata[DIM_W-1:0];
                REG_MASK_HEIGHT:  msk_h_reg <= cfg_wdata[DIM_W-1:0];
                REG_OFFSET_X:     ofs_x_reg <= cfg_wdata;
                REG_OFFSET_Y:     ofs_y_reg <= cfg_wdata;
                REG_MASK_MODE:    mode_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    logic [DIM_W-1:0] img_w, img_h, msk_w, msk_h;
    assign img_w = clamp_dim(img_w_reg);
    assign img_h = clamp_dim(img_h_reg);
    assign msk_w = clamp_dim(msk_w_reg);
    assign msk_h = clamp_dim(msk_h_reg);

    // whole pipeline moves together when the output register can take an item
    logic adv;
    logic acc;
    logic acc_pix;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;
    assign acc_pix  = acc && (s_tuser == REQ_PIXEL);

    cnt_t cnt;

    oam_cnt u_cnt (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (acc_pix),
        .width  (img_w),
        .height (img_h),
        .status (cnt)
    );

    // mask-relative position of the current pixel
    logic signed [OFS_W:0] mx_s, my_s;
    logic                  covered;
    assign mx_s = $signed({3'b000, cnt.col}) - $signed({ofs_x_reg[OFS_W-1], ofs_x_reg});
    assign my_s = $signed({3'b000, cnt.row}) - $signed({ofs_y_reg[OFS_W-1], ofs_y_reg});
    assign covered = !mx_s[OFS_W] && !my_s[OFS_W]
                  && (mx_s[OFS_W-1:0] < {1'b0, img_w}) && (my_s[OFS_W-1:0] < {1'b0, img_h})
                  && (mx_s[OFS_W-1:0] < {1'b0, msk_w}) && (my_s[OFS_W-1:0] < {1'b0, msk_h});

    // stage 1: captured item
    logic             s1_valid_reg;
    logic             s1_pix_reg;
    logic [IDX_W-1:0] s1_widx_reg;
    logic [7:0]       s1_wdata_reg;
    logic [23:0]      s1_rgb_reg;
    logic [7:0]       s1_alpha_reg;
    logic             s1_cov_reg;
    logic [CNT_W-1:0] s1_mx_reg, s1_my_reg;
    logic             s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg   <= s_tuser;
            s1_widx_reg  <= s_tdata[15:0];
            s1_wdata_reg <= s_tdata[23:16];
            s1_rgb_reg   <= s_tdata[47:24];
            s1_alpha_reg <= s_tdata[55:48];
            s1_cov_reg   <= covered;
            s1_mx_reg    <= mx_s[CNT_W-1:0];
            s1_my_reg    <= my_s[CNT_W-1:0];
            s1_last_reg  <= cnt.last;
        end
    end

    // stage 1 logic: mask address and store writes
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] widx_ext;
    logic             pos_ok, widx_ok;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    assign pos      = POS_W'(s1_my_reg) * POS_W'(msk_w) + POS_W'(s1_mx_reg);
    assign pos_ok   = pos < POS_W'(MASK_PIXELS);
    assign widx_ext = POS_W'(s1_widx_reg);
    assign widx_ok  = widx_ext < POS_W'(MASK_PIXELS);
    assign ram_we   = adv && s1_valid_reg && (s1_pix_reg == REQ_MASK) && widx_ok;

    oam_ram #(
        .WIDTH (8),
        .DEPTH (MASK_PIXELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata (s1_wdata_reg),
        .re    (adv),
        .raddr (pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    // stage 2: waits on the mask byte
    logic        s2_valid_reg;
    logic [23:0] s2_rgb_reg;
    logic [7:0]  s2_alpha_reg;
    logic        s2_cov_reg;
    logic        s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_pix_reg == REQ_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rgb_reg   <= s1_rgb_reg;
            s2_alpha_reg <= s1_alpha_reg;
            s2_cov_reg   <= s1_cov_reg && pos_ok;
            s2_last_reg  <= s1_last_reg;
        end
    end

    logic [7:0] alpha_next;

    always_comb
    begin
        case (mode_reg)
            MODE_HOLLOW: alpha_next = s2_cov_reg ? (s2_alpha_reg & ~ram_rdata) : s2_alpha_reg;
            default:     alpha_next = s2_cov_reg ? (s2_alpha_reg & ram_rdata) : 8'h00;
        endcase
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {alpha_next, s2_rgb_reg};
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // a mask write never turns into a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && (s1_pix_reg == REQ_MASK)) |=> !s2_valid_reg)
        else $error("mask write reached result stage");

    // uncovered pixel in cutout mode comes out fully transparent
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && !s2_cov_reg && (mode_reg == MODE_CUTOUT))
        |=> (m_tdata[31:24] == 8'h00))
        else $error("cutout alpha not cleared outside mask");

    // the frame's last pixel sends the raster back to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_pix && cnt.last) |=> (cnt.col == '0 && cnt.row == '0))
        else $error("raster counters did not wrap at frame end");

    // a pixel with last set leaves the block flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && s2_last_reg) |=> (m_tvalid && m_tlast))
        else $error("last flag lost in pipeline");

endmodule
